[rtl/core/assert_macros.svh]
// assertion helpers, clocked on aclk and disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_SAME(lbl, ante, cons, msg)

`define AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/oxwa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package oxwa_pkg;

    localparam int WIN_DEPTH  = 128;
    localparam int IDX_W      = $clog2(WIN_DEPTH);
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
    localparam int VAL_W      = 35;
    localparam int SUM_W      = VAL_W + IDX_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int KEY_W      = 16;
    localparam int CUR_W      = 15;
    localparam int GAIN_W     = 12;
    localparam int FRAC_W     = 8;
    localparam int PROD1_W    = KEY_W + CUR_W;
    localparam int PROD2_W    = PROD1_W + GAIN_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [KEY_W-1:0]  DEFAULT_KEY   = 16'd174;
    localparam logic [7:0]        RST_WIN_LEN   = 8'd10;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 12'd256;
    localparam logic [KEY_W-1:0]  RST_FB_KEY    = 16'd174;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_KEY  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_EN   = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SCAN,
        ST_DRAIN,
        ST_WR0,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic scan;
        logic wr0;
        logic div;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_err;
        logic scan_last;
        logic div_last;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/oxwa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module oxwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/oxwa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module oxwa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire oxwa_pkg::sts_t sts,
    output oxwa_pkg::cmd_t      cmd
);

    import oxwa_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_err ? ST_FIN : ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read of the shift pass lands this cycle
                state_next = ST_WR0;
            end
            ST_WR0: begin
                cmd.wr0    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/oxwa_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module oxwa_dpath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [oxwa_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                      s_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [oxwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [oxwa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire oxwa_pkg::cmd_t                  cmd,
    output oxwa_pkg::sts_t                       sts,
    output logic [oxwa_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [0:0]                           m_tuser
);

    import oxwa_pkg::*;

    // configuration
    logic [7:0]        wl_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [KEY_W-1:0]  fbk_reg;
    logic              fben_reg;
    logic [CNT_W-1:0]  len;

    // per item
    logic [KEY_W-1:0]     key_reg;
    logic [CUR_W-1:0]     cur_reg;
    logic                 err_reg;
    logic [PROD1_W-1:0]   prod1_reg;
    logic [VAL_W-1:0]     oxy_reg;
    logic [PROD2_W-1:0]   prod2;
    logic [KEY_W-1:0]     key_sel;
    logic [CUR_W-1:0]     cur_sum;

    // window pass
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [IDX_W-1:0]     j_reg;
    logic                 issue;
    logic                 shift;
    logic                 pend_v_reg;
    logic                 pend_shift_reg;
    logic [IDX_W-1:0]     pend_addr_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [IDX_W-1:0]     ram_raddr;
    logic [IDX_W-1:0]     ram_waddr;
    logic [VAL_W-1:0]     ram_wdata;
    logic [VAL_W-1:0]     ram_rdata;
    logic                 ram_we;

    // divider
    logic [CNT_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [CNT_W:0]       trial;
    logic                 qbit;

    logic [VAL_W-1:0]     avg_reg;
    logic                 status_reg;

    assign len = (wl_reg > CNT_W'(WIN_DEPTH)) ? CNT_W'(WIN_DEPTH) : wl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= RST_WIN_LEN;
            gain_reg <= RST_GAIN;
            fbk_reg  <= RST_FB_KEY;
            fben_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIN_LEN: wl_reg <= cfg_data[7:0];
                CFG_GAIN: begin
                    if (cfg_data[GAIN_W-1:0] != '0) begin
                        gain_reg <= cfg_data[GAIN_W-1:0];
                    end
                end
                CFG_FB_KEY: begin
                    if (cfg_data != '0) begin
                        fbk_reg <= cfg_data;
                    end
                end
                CFG_FB_EN: fben_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign sts.in_err = s_tuser[0] || (wl_reg == '0);

    always_comb begin
        if (s_tdata[15:0] != '0) begin
            key_sel = s_tdata[15:0];
        end else if (fben_reg) begin
            key_sel = fbk_reg;
        end else begin
            key_sel = DEFAULT_KEY;
        end
        cur_sum = CUR_W'(s_tdata[23:16]) * CUR_W'(100)
                + CUR_W'(s_tdata[31:24]) * CUR_W'(10)
                + CUR_W'(s_tdata[39:32]);
    end

    assign prod2 = PROD2_W'(prod1_reg) * PROD2_W'(gain_reg);
    assign fill_next = (fill_reg < len) ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_sel;
            cur_reg <= cur_sum;
            err_reg <= sts.in_err;
        end
        if (cmd.mul1) begin
            prod1_reg <= PROD1_W'(key_reg) * PROD1_W'(cur_reg);
        end
        if (cmd.mul2) begin
            oxy_reg <= prod2[PROD2_W-1:FRAC_W];
        end
    end

    // shift pass: entry j takes entry j-1 below the window length, entries
    // at and beyond it stay put but still count in the sum
    assign issue     = cmd.scan && (j_reg != '0);
    assign shift     = {1'b0, j_reg} < len;
    assign ram_raddr = shift ? j_reg - 1'b1 : j_reg;
    assign sts.scan_last = (j_reg[IDX_W-1:1] == '0);

    assign ram_we    = (pend_v_reg && pend_shift_reg) || cmd.wr0;
    assign ram_waddr = cmd.wr0 ? '0 : pend_addr_reg;
    assign ram_wdata = cmd.wr0 ? oxy_reg : ram_rdata;

    oxwa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            pend_v_reg <= 1'b0;
        end else begin
            if (cmd.mul2) begin
                fill_reg <= fill_next;
            end
            pend_v_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= j_reg;
        pend_shift_reg <= shift;
        if (cmd.mul2) begin
            j_reg <= IDX_W'(fill_next - 1'b1);
        end else if (issue) begin
            j_reg <= j_reg - 1'b1;
        end
    end

    // restoring division of the window sum by the fill count, one bit a cycle
    assign trial = {rem_reg, sum_reg[SUM_W-1]};
    assign qbit  = trial >= {1'b0, fill_reg};
    assign sts.div_last = (dcnt_reg == DIV_CNT_W'(SUM_W - 1));

    always_ff @(posedge aclk) begin
        if (cmd.mul2) begin
            sum_reg <= '0;
        end else if (pend_v_reg) begin
            sum_reg <= sum_reg + SUM_W'(ram_rdata);
        end else if (cmd.wr0) begin
            sum_reg  <= sum_reg + SUM_W'(oxy_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div) begin
            sum_reg  <= {sum_reg[SUM_W-2:0], qbit};
            rem_reg  <= qbit ? CNT_W'(trial - {1'b0, fill_reg}) : trial[CNT_W-1:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            status_reg <= err_reg;
            avg_reg    <= err_reg ? '0 : sum_reg[VAL_W-1:0];
        end
    end

    assign m_tdata = OUT_DATA_W'(avg_reg);
    assign m_tuser = status_reg;

endmodule

`default_nettype wire

[rtl/core/oxygen_reading_window_average.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tdata (40), s_tuser (1)
// m_        out        m_tvalid / m_tready  m_tdata (40), m_tuser (1)
// cfg_      in         cfg_valid/cfg_ready  cfg_index (8), cfg_data (16)
//
// one reading at a time: after accept, the window shift and sum pass through
// the single-port-pair window ram (one entry a cycle) and the 42-step
// restoring divider run before the result is loaded and the next reading is
// accepted. a failed read or a zero window length skips both and goes straight
// to the result load. reset clears the fill count, config and handshake state;
// the window ram is not cleared. a stalled m_ side holds the finished result in
// the output register and the block waits before loading the next one.

module oxygen_reading_window_average (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // key_word[15:0], current_units[23:16], current_tenths[31:24],
    // current_hundredths[39:32]
    input  wire logic [39:0] s_tdata,
    // read_failed[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // o2_average[34:0], zero fill above
    output logic [39:0]      m_tdata,
    // status[0]
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    import oxwa_pkg::*;

`include "assert_macros.svh"

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    oxwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oxwa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // only one reading in flight
    `AST_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `AST_SAME(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
    `AST_NEXT(a_out_valid, cmd.out_load, m_tvalid, "result loaded but not presented")
    `AST_SAME(a_err_zero, m_tvalid && m_tuser[0], m_tdata == '0, "error with nonzero average")

endmodule

`default_nettype wire
